FILE: design/kss_pkg.sv
// Shared types and constants for the k-sorted stream sorter.
`default_nettype none

package kss_pkg;

    // Size of the cell row and width of one stream value.
    localparam int MAX_WINDOW = 8;
    localparam int VALUE_BITS = 32;

    // Width of the window register and its value after reset.
    localparam int CFG_BITS = 4;
    localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(8);

    // Bits needed to select one cell of the row.
    localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    // Operation broadcast to every cell.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REPLACE,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_value   value;
    } t_cell_cmd;

    // What a cell shows to its neighbors: its entry, and whether the entry
    // is empty or larger than the broadcast value.
    typedef struct packed {
        logic   vld;
        logic   gt;
        t_value val;
    } t_cell_link;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

FILE: design/kss_cell.sv
// One cell of the sorted row: holds one entry and trades it with its neighbors.
`default_nettype none

module kss_cell
    import kss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_cmd  i_cmd,
    input  wire t_cell_link i_left,
    input  wire t_cell_link i_right,
    output t_cell_link      o_link
);

    logic   r_vld;
    logic   n_vld;
    t_value r_val;
    t_value n_val;
    logic   w_gt;

    // An empty cell counts as larger than any value.
    assign w_gt   = !r_vld || ($signed(r_val) > $signed(i_cmd.value));
    assign o_link = '{vld: r_vld, gt: w_gt, val: r_val};

    // Next entry for each row operation.
    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        unique case (i_cmd.op)
            OP_HOLD: begin
                n_vld = r_vld;
                n_val = r_val;
            end
            OP_INSERT: begin
                // Larger entries move one place up to open a slot.
                n_vld = r_vld || i_left.vld;
                if (w_gt) begin
                    n_val = i_left.gt ? i_left.val : i_cmd.value;
                end
            end
            OP_REPLACE: begin
                // The head leaves; smaller entries move down, the new value
                // takes the slot between them and the larger ones.
                if (!i_right.gt) begin
                    n_val = i_right.val;
                end else if (!w_gt) begin
                    n_val = i_cmd.value;
                end
            end
            OP_SHIFT: begin
                n_vld = i_right.vld;
                n_val = i_right.val;
            end
        endcase
    end

    // Occupancy is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

FILE: design/k_sorted_stream_sorter_unit.sv
// Top level of the k-sorted stream sorter: cell row, control and output register.
//
// Sorts a stream in which no value is more than k places from its sorted
// position, with k set by the window register (0 acts as 1, values above the
// row length act as the row length). Values are held in a row of cells kept in
// ascending order. For each beat that is not marked last, the row either
// inserts the value or, once k values are held, emits the smallest of the held
// values and the new one and keeps the rest. A beat marked last is handled the
// same way and is followed by a flush in which the row shifts one place per
// output beat, one beat for each held value, at most MAX_WINDOW + 1 output
// beats in all with the last beat's own; no input is taken during the flush.
// The final flushed beat carries last_res. Input is taken while the output
// register is free or being emptied in the same cycle.
`default_nettype none

module k_sorted_stream_sorter_unit
    import kss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_window_k_we,
    input  wire logic [CFG_BITS-1:0]   i_window_k,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [VALUE_BITS-1:0]      o_sorted_value,
    output logic                       o_last_res
);

    logic [CFG_BITS-1:0] r_window_k;
    t_state              r_state;
    t_state              n_state;
    logic                r_out_vld;
    t_value              r_out_val;
    logic                r_out_last;

    t_cell_cmd           w_cmd;
    t_cell_link          w_link [0:MAX_WINDOW+1];
    logic [MAX_WINDOW-1:0] w_vld;
    logic [IDX_BITS-1:0] w_full_idx;
    logic                w_full;
    logic                w_out_free;
    logic                w_load;
    t_value              w_load_val;
    logic                w_load_last;

    // Window register, written whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_k <= WINDOW_RESET;
        end else if (i_window_k_we) begin
            r_window_k <= i_window_k;
        end
    end

    // Cell that is occupied exactly when the window is full.
    always_comb begin
        if (r_window_k == '0) begin
            w_full_idx = '0;
        end else if (int'(r_window_k) > MAX_WINDOW) begin
            w_full_idx = IDX_BITS'(MAX_WINDOW - 1);
        end else begin
            w_full_idx = IDX_BITS'(r_window_k - 1'b1);
        end
    end

    assign w_full = w_vld[w_full_idx];

    // Row boundaries: an always-full cell below the head, an empty one above.
    assign w_link[0]            = '{vld: 1'b1, gt: 1'b0, val: '0};
    assign w_link[MAX_WINDOW+1] = '{vld: 1'b0, gt: 1'b1, val: '0};

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        kss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_link[g]),
            .i_right (w_link[g+2]),
            .o_link  (w_link[g+1])
        );
        assign w_vld[g] = w_link[g+1].vld;
    end

    assign w_out_free = !r_out_vld || i_out_ready;

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, row operation and output loading.
    always_comb begin
        n_state      = r_state;
        w_cmd.op     = OP_HOLD;
        w_cmd.value  = i_value;
        o_in_ready   = 1'b0;
        w_load       = 1'b0;
        w_load_val   = w_link[1].val;
        w_load_last  = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                o_in_ready = w_out_free;
                if (i_in_valid && w_out_free) begin
                    if (w_full) begin
                        w_load = 1'b1;
                        if (w_link[1].gt) begin
                            // New value is the smallest: pass it straight on.
                            w_load_val = i_value;
                            w_cmd.op   = OP_HOLD;
                        end else begin
                            w_load_val = w_link[1].val;
                            w_cmd.op   = OP_REPLACE;
                        end
                    end else begin
                        w_cmd.op = OP_INSERT;
                    end
                    if (i_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_load_val  = w_link[1].val;
                    w_load_last = !w_link[2].vld;
                    w_cmd.op    = OP_SHIFT;
                    if (!w_link[2].vld) begin
                        n_state = ST_RUN;
                    end
                end
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_val  <= w_load_val;
            r_out_last <= w_load_last;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_sorted_value = r_out_val;
    assign o_last_res     = r_out_last;

`ifndef SYNTHESIS
    // Occupied cells always form an unbroken run from the head.
    a_vld_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((({1'b0, w_vld} + 1'b1) & {1'b0, w_vld}) == '0))
        else $error("cell row has a hole");

    // A beat marked last always starts a flush.
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_last) |=> (r_state == ST_FLUSH))
        else $error("last beat did not start a flush");

    // A flush never runs on an empty row.
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> w_vld[0])
        else $error("flush with an empty row");

    // An accepted beat that is not marked last never lowers occupancy.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_last)
            |=> ($countones(w_vld) >= $past($countones(w_vld))))
        else $error("held value lost");
`endif

endmodule

`default_nettype wire
